// ===== src/olt_pkg.sv =====
// shared constants, codes and types for the ordered list table
package olt_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int POS_W    = 4;
  localparam int OCNT_W   = 5;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_APPEND = 2'd0;
  localparam mode_t MODE_SEARCH = 2'd1;
  localparam mode_t MODE_REMOVE = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_DONE = 2'd0;
  localparam status_t ST_MISS = 2'd1;
  localparam status_t ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } olt_state_t;

endpackage

// ===== src/ordered_list_table.sv =====
// ordered list table: append, search and remove over a 16-entry value store
//
//   channel  direction  handshake            fields
//   in_      input      start & !busy        in_mode, in_value
//   out_     output     out_valid (1 cycle)  out_status, out_position, out_count
//
// append, or any op on an empty table or with an unused mode: result in the next cycle
// search: walks the entries in order through the single read port
// remove: the walk up to the match, then a shift of each entry from the match to the tail
//   down by one place
// reset clears the count and control; the store itself is not cleared
// busy stays high while a walk or shift runs; the receiver cannot stall results
module ordered_list_table (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  olt_pkg::mode_t               in_mode,
  input  logic signed [olt_pkg::VAL_W-1:0] in_value,
  output logic                         out_valid,
  output olt_pkg::status_t             out_status,
  output logic [olt_pkg::POS_W-1:0]    out_position,
  output logic [olt_pkg::OCNT_W-1:0]   out_count
);
  import olt_pkg::*;

  // value store, one write and one registered read port
  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rdata_r;
  logic [IDX_W-1:0] raddr;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [VAL_W-1:0] wdata;

  // control and working registers
  olt_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [VAL_W-1:0] key_r, key_nxt;
  logic             rem_r, rem_nxt;
  logic             valid_r, valid_nxt;
  status_t          status_r, status_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;

  logic             accept;
  logic             last_entry;
  logic             hit;

  assign accept     = start && (state_r == S_IDLE);
  assign last_entry = (CNT_W'(ptr_r) + CNT_W'(1)) == count_r;
  assign hit        = (rdata_r == key_r);

  // store access
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // sequencer: next state, store control and result
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    key_nxt    = key_r;
    rem_nxt    = rem_r;
    pos_nxt    = pos_r;
    valid_nxt  = 1'b0;
    status_nxt = status_r;
    we         = 1'b0;
    waddr      = ptr_r;
    wdata      = rdata_r;
    raddr      = ptr_r + IDX_W'(1);
    unique case (state_r)
      S_IDLE: begin
        raddr = '0;
        if (accept) begin
          key_nxt = in_value;
          ptr_nxt = '0;
          rem_nxt = (in_mode == MODE_REMOVE);
          pos_nxt = '0;
          if (in_mode == MODE_APPEND) begin
            valid_nxt = 1'b1;
            if (count_r >= CNT_W'(CAPACITY)) begin
              status_nxt = ST_FULL;
            end else begin
              we         = 1'b1;
              waddr      = IDX_W'(count_r);
              wdata      = in_value;
              pos_nxt    = IDX_W'(count_r);
              count_nxt  = count_r + CNT_W'(1);
              status_nxt = ST_DONE;
            end
          end else if ((in_mode == MODE_SEARCH || in_mode == MODE_REMOVE) &&
                       count_r != '0) begin
            state_nxt = S_SCAN;
          end else begin
            valid_nxt  = 1'b1;
            status_nxt = ST_MISS;
          end
        end
      end
      S_SCAN: begin
        // rdata_r holds entry ptr_r; the read issued now fetches ptr_r + 1
        if (hit) begin
          pos_nxt = ptr_r;
          if (rem_r) begin
            state_nxt = S_SHIFT;
          end else begin
            state_nxt  = S_IDLE;
            valid_nxt  = 1'b1;
            status_nxt = ST_DONE;
          end
        end else if (last_entry) begin
          state_nxt  = S_IDLE;
          valid_nxt  = 1'b1;
          status_nxt = ST_MISS;
          pos_nxt    = '0;
        end else begin
          ptr_nxt = ptr_r + IDX_W'(1);
        end
      end
      S_SHIFT: begin
        // rdata_r holds entry ptr_r + 1; move it down and fetch the next
        raddr = ptr_r + IDX_W'(2);
        if (last_entry) begin
          state_nxt  = S_IDLE;
          valid_nxt  = 1'b1;
          status_nxt = ST_DONE;
          count_nxt  = count_r - CNT_W'(1);
        end else begin
          we      = 1'b1;
          ptr_nxt = ptr_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    key_r    <= key_nxt;
    rem_r    <= rem_nxt;
    pos_r    <= pos_nxt;
    status_r <= status_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = valid_r;
  assign out_status   = status_r;
  assign out_position = POS_W'(pos_r);
  assign out_count    = OCNT_W'(count_r);

`ifndef SYNTHESIS
  // count never runs past the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // a result always leaves the sequencer free
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> state_r == S_IDLE)
    else $error("result shown while still busy");

  // table full only reported with a full table
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && status_r == ST_FULL) |-> count_r == CNT_W'(CAPACITY))
    else $error("full status with room left");

  // a removal lowers the count by one
  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && last_entry) |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("count not decremented on removal");
`endif

endmodule

// ===== test/ordered_list_table_tb.sv =====
// self-checking testbench for the ordered list table: directed table, then random traffic
module ordered_list_table_tb;
  import olt_pkg::*;

  // mode code with no operation behind it
  localparam mode_t MODE_UNUSED = 2'd3;
  localparam int    RANDOM_OPS  = 620;
  localparam int    CALM_TAIL   = 100;
  localparam int    SETTLE      = 2 * CAPACITY + 8;
  localparam int    N_ROWS      = 15;

  typedef struct packed {
    status_t             status;
    logic [POS_W-1:0]    position;
    logic [OCNT_W-1:0]   count;
  } list_result_t;

  typedef struct {
    mode_t        mode;
    logic [31:0]  value;
    int           reps;
    bit           typed;
    list_result_t want;
  } op_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  mode_t                   in_mode;
  logic signed [VAL_W-1:0] in_value;
  logic                    out_valid;
  status_t                 out_status;
  logic [POS_W-1:0]        out_position;
  logic [OCNT_W-1:0]       out_count;

  // expectation typed in the directed table, travels with the transaction
  bit                      row_typed;
  list_result_t            row_want;

  // shadow copy of the list
  logic [31:0]             list_vals [CAPACITY];
  int                      list_len;

  list_result_t            pending_outcomes [$];
  int                      mismatches;
  logic [31:0]             value_pool [8];
  op_row_t                 directed_ops [N_ROWS];

  ordered_list_table i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_mode      (in_mode),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_position (out_position),
    .out_count    (out_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #(4_000_000);
    $display("ordered_list_table_tb NOT OK");
    $finish;
  end

  // apply one operation to the shadow list and return its outcome
  function automatic list_result_t predict_list_op(input mode_t m, input logic [31:0] v);
    list_result_t r;
    int           hit;
    int           i;
    r.status   = ST_MISS;
    r.position = '0;
    hit        = -1;
    for (i = 0; i < list_len; i++) begin
      if (hit < 0 && list_vals[i] == v) hit = i;
    end
    case (m)
      MODE_APPEND: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          list_vals[list_len] = v;
          r.position          = POS_W'(list_len);
          list_len++;
          r.status            = ST_DONE;
        end
      end
      MODE_SEARCH: begin
        if (hit >= 0) begin
          r.status   = ST_DONE;
          r.position = POS_W'(hit);
        end
      end
      MODE_REMOVE: begin
        if (hit >= 0) begin
          for (i = hit; i < list_len - 1; i++) list_vals[i] = list_vals[i + 1];
          list_len--;
          r.status   = ST_DONE;
          r.position = POS_W'(hit);
        end
      end
      default: begin
      end
    endcase
    r.count = OCNT_W'(list_len);
    return r;
  endfunction

  // results are checked first, then an accepted transaction queues its outcome
  always @(posedge clk) begin : watch
    list_result_t exp_res;
    list_result_t outcome;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_outcomes.size() == 0) begin
          $error("result with nothing pending: status %0d position %0d count %0d",
                 out_status, out_position, out_count);
          mismatches++;
        end else begin
          exp_res = pending_outcomes.pop_front();
          if (out_status !== exp_res.status) begin
            $error("out_status: expected %0d, got %0d", exp_res.status, out_status);
            mismatches++;
          end
          if (out_position !== exp_res.position) begin
            $error("out_position: expected %0d, got %0d", exp_res.position, out_position);
            mismatches++;
          end
          if (out_count !== exp_res.count) begin
            $error("out_count: expected %0d, got %0d", exp_res.count, out_count);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        outcome = predict_list_op(in_mode, in_value);
        pending_outcomes.push_back(row_typed ? row_want : outcome);
      end
    end
  end

  // offer one transaction and hold it until accepted
  task automatic issue_op(input mode_t m, input logic [31:0] v, input bit typed,
                          input list_result_t want);
    start     <= 1'b1;
    in_mode   <= m;
    in_value  <= v;
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk); while (busy);
  endtask

  // idle burst with junk on the payload
  task automatic hold_off(input int cycles);
    start    <= 1'b0;
    in_mode  <= mode_t'($urandom_range(0, 3));
    in_value <= $urandom();
    repeat (cycles) @(posedge clk);
  endtask

  // wait until every queued outcome has been seen
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_outcomes.size() != 0);
  endtask

  // value biased towards hits on the current list contents
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40 && list_len > 0) return list_vals[$urandom_range(0, list_len - 1)];
    if (r < 80) return value_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  // operation mix leans towards filling or towards draining
  function automatic mode_t pick_mode(input bit growing);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return MODE_UNUSED;
    if (growing) begin
      if (r < 63) return MODE_APPEND;
      if (r < 85) return MODE_SEARCH;
      return MODE_REMOVE;
    end
    if (r < 18) return MODE_APPEND;
    if (r < 45) return MODE_SEARCH;
    return MODE_REMOVE;
  endfunction

  initial begin : stimulus
    int           n;
    int           k;
    bit           growing;
    list_result_t none;
    none       = '0;
    start      = 1'b0;
    rst_n      = 1'b0;
    in_mode    = MODE_APPEND;
    in_value   = '0;
    row_typed  = 1'b0;
    row_want   = '0;
    list_len   = 0;
    mismatches = 0;
    value_pool = '{32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                   32'h0000_0001, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_8000};

    // directed walk: empty table, extremes, duplicates, full table, head and tail removal
    directed_ops = '{
      '{MODE_SEARCH, 32'h0000_0000,  1, 1'b1, '{ST_MISS, 4'd0,  5'd0}},
      '{MODE_REMOVE, 32'h0000_0005,  1, 1'b1, '{ST_MISS, 4'd0,  5'd0}},
      '{MODE_APPEND, 32'h7fff_ffff,  1, 1'b1, '{ST_DONE, 4'd0,  5'd1}},
      '{MODE_APPEND, 32'h8000_0000,  1, 1'b1, '{ST_DONE, 4'd1,  5'd2}},
      '{MODE_APPEND, 32'h7fff_ffff,  1, 1'b1, '{ST_DONE, 4'd2,  5'd3}},
      '{MODE_SEARCH, 32'h7fff_ffff,  1, 1'b1, '{ST_DONE, 4'd0,  5'd3}},
      '{MODE_SEARCH, 32'hffff_ffff,  1, 1'b1, '{ST_MISS, 4'd0,  5'd3}},
      '{MODE_REMOVE, 32'h7fff_ffff,  1, 1'b1, '{ST_DONE, 4'd0,  5'd2}},
      '{MODE_SEARCH, 32'h7fff_ffff,  1, 1'b1, '{ST_DONE, 4'd1,  5'd2}},
      '{MODE_UNUSED, 32'h7fff_ffff,  1, 1'b1, '{ST_MISS, 4'd0,  5'd2}},
      '{MODE_APPEND, 32'h0000_0000, 14, 1'b0, '{ST_DONE, 4'd0,  5'd0}},
      '{MODE_APPEND, 32'hffff_ffff,  1, 1'b1, '{ST_FULL, 4'd0,  5'd16}},
      '{MODE_SEARCH, 32'h0000_000d,  1, 1'b1, '{ST_DONE, 4'd15, 5'd16}},
      '{MODE_REMOVE, 32'h0000_000d,  1, 1'b1, '{ST_DONE, 4'd15, 5'd15}},
      '{MODE_REMOVE, 32'h8000_0000,  1, 1'b1, '{ST_DONE, 4'd0,  5'd14}}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_ops[i]) begin
      for (k = 0; k < directed_ops[i].reps; k++) begin
        issue_op(directed_ops[i].mode, directed_ops[i].value + k,
                 directed_ops[i].typed, directed_ops[i].want);
        if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 7));
      end
    end
    drain();

    // random traffic in filling and draining spells
    growing = 1'b0;
    for (n = 0; n < RANDOM_OPS; n++) begin
      if (n % 40 == 0) growing = $urandom_range(0, 1);
      issue_op(pick_mode(growing), pick_value(), 1'b0, none);
      if (n % 150 == 149) begin
        drain();
      end else if (n < RANDOM_OPS - CALM_TAIL && (n / 25) % 3 != 2
                   && $urandom_range(0, 2) == 0) begin
        hold_off($urandom_range(1, 7));
      end
    end

    // let the last results come out
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("ordered_list_table_tb OK");
    end else begin
      $display("ordered_list_table_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== ordered_list_table.f =====
src/olt_pkg.sv
src/ordered_list_table.sv
test/ordered_list_table_tb.sv
